// ===== sv/rpn_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package rpn_pkg;

    // Default sizing
    localparam int DEF_STACK_DEPTH = 16;
    localparam int DEF_DATA_WIDTH  = 32;

    // Fixed field widths on the stream ports
    localparam int CMD_W    = 4;
    localparam int NUMBER_W = 31;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 40;

    // Token codes
    localparam logic [CMD_W-1:0] CMD_PUSH   = 4'd0;
    localparam logic [CMD_W-1:0] CMD_ADD    = 4'd1;
    localparam logic [CMD_W-1:0] CMD_SUB    = 4'd2;
    localparam logic [CMD_W-1:0] CMD_MUL    = 4'd3;
    localparam logic [CMD_W-1:0] CMD_DIV    = 4'd4;
    localparam logic [CMD_W-1:0] CMD_SHL    = 4'd5;
    localparam logic [CMD_W-1:0] CMD_SHR    = 4'd6;
    localparam logic [CMD_W-1:0] CMD_XOR    = 4'd7;
    localparam logic [CMD_W-1:0] CMD_OR     = 4'd8;
    localparam logic [CMD_W-1:0] CMD_AND    = 4'd9;
    localparam logic [CMD_W-1:0] CMD_FINISH = 4'd10;

    // Status codes
    localparam logic [STATUS_W-1:0] STS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STS_UNDERFLOW = 2'd1;
    localparam logic [STATUS_W-1:0] STS_OVERFLOW  = 2'd2;
    localparam logic [STATUS_W-1:0] STS_DIV_ZERO  = 2'd3;

    // Request to the multiply/divide unit
    typedef struct packed {
        logic start;
        logic op_div;
    } t_iter_ctl;

endpackage

`default_nettype wire

// ===== sv/rpn_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rpn_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== sv/rpn_iter.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rpn_iter
    import rpn_pkg::*;
#(
    parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_iter_ctl             i_ctl,
    input  wire logic [DATA_WIDTH-1:0] i_a,
    input  wire logic [DATA_WIDTH-1:0] i_b,
    output logic                       o_done,
    output logic      [DATA_WIDTH-1:0] o_result
);

    localparam int W  = DATA_WIDTH;
    localparam int CW = $clog2(W);

    logic          r_busy, r_done, r_div, r_neg;
    logic [CW-1:0] r_cnt;
    logic [W:0]    r_x;     // product accumulator or partial remainder
    logic [W-1:0]  r_y;     // multiplier bits or dividend/quotient
    logic [W-1:0]  r_z;     // multiplicand or divisor

    logic          a_neg, b_neg;
    logic [W-1:0]  a_mag, b_mag;
    logic [W-1:0]  mul_sum;
    logic [W:0]    rem_s, diff;

    // Operand magnitudes for signed division
    assign a_neg = i_a[W-1];
    assign b_neg = i_b[W-1];
    assign a_mag = a_neg ? (W'(0) - i_a) : i_a;
    assign b_mag = b_neg ? (W'(0) - i_b) : i_b;

    // One step of shift-add multiply and restoring divide
    assign mul_sum = r_x[W-1:0] + (r_y[0] ? r_z : W'(0));
    assign rem_s   = {r_x[W-1:0], r_y[W-1]};
    assign diff    = rem_s - {1'b0, r_z};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CW'(1);
                if (r_cnt == CW'(W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_div <= i_ctl.op_div;
            r_x   <= '0;
            if (i_ctl.op_div) begin
                r_y   <= a_mag;
                r_z   <= b_mag;
                r_neg <= a_neg ^ b_neg;
            end else begin
                r_y   <= i_b;
                r_z   <= i_a;
                r_neg <= 1'b0;
            end
        end else if (r_busy) begin
            if (r_div) begin
                r_x <= diff[W] ? rem_s : diff;
                r_y <= {r_y[W-2:0], ~diff[W]};
            end else begin
                r_x <= {1'b0, mul_sum};
                r_y <= r_y >> 1;
                r_z <= r_z << 1;
            end
        end
    end

    assign o_done   = r_done;
    assign o_result = r_div ? (r_neg ? (W'(0) - r_y) : r_y) : r_x[W-1:0];

endmodule

`default_nettype wire

// ===== sv/rpn_stack_evaluator_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Postfix evaluator. Tokens arrive on the slave stream (command in tdata[3:0],
// literal in tdata[34:4]); a finish token returns the top of stack and the first
// error since the last finish on the master stream, then empties the stack.
// The top of stack sits in a register and the entries below it in a one-port-
// write, registered-read RAM. Push, finish, ignored codes and operators that
// underflow end in the idle state. Add, sub, shifts and logic pass the execute
// state for the registered read of the second operand from the RAM. Multiply
// and divide go on to the iterate state and the bit-serial multiply/divide
// unit; a divide by zero ends in execute. No token is taken while a result
// waits in the output register with tready low. No clearing pass follows reset.
module rpn_stack_evaluator_unit
    import rpn_pkg::*;
#(
    parameter int STACK_DEPTH = DEF_STACK_DEPTH,
    parameter int DATA_WIDTH  = DEF_DATA_WIDTH
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_s_axis_tvalid,
    output logic                      o_s_axis_tready,
    input  wire logic [S_TDATA_W-1:0] i_s_axis_tdata,  // command[3:0], number[34:4], zero pad
    output logic                      o_m_axis_tvalid,
    input  wire logic                 i_m_axis_tready,
    output logic      [M_TDATA_W-1:0] o_m_axis_tdata   // value[31:0], status[33:32], zero pad
);

    localparam int W     = DATA_WIDTH;
    localparam int AW    = $clog2(STACK_DEPTH);
    localparam int CNT_W = $clog2(STACK_DEPTH + 1);
    localparam int VEXT_W = (W > VALUE_W) ? W : VALUE_W;
    localparam int NEXT_W = (W > NUMBER_W) ? W : NUMBER_W;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_ITER = 2'd2;

    logic [1:0]          r_state, n_state;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic [STATUS_W-1:0] r_err, n_err;
    logic [CMD_W-1:0]    r_cmd, n_cmd;
    logic [W-1:0]        r_tos, n_tos;
    logic                r_ov, n_ov;
    logic [VALUE_W-1:0]  r_val, n_val;
    logic [STATUS_W-1:0] r_sts, n_sts;

    logic                s_acc;
    logic [CMD_W-1:0]    cmd;
    logic [NUMBER_W-1:0] number;
    logic [NEXT_W-1:0]   num_ext;
    logic [VEXT_W-1:0]   tos_ext;
    logic                is_op;

    logic                ram_we;
    logic [AW-1:0]       ram_waddr, ram_raddr;
    logic [W-1:0]        ram_rdata;
    logic [CNT_W-1:0]    cnt_m1, cnt_m2;

    t_iter_ctl           iter_ctl;
    logic                iter_done;
    logic [W-1:0]        iter_res;

    logic [W-1:0]        opl, opr, alu_res;
    logic [4:0]          sh_amt;

    // Input fields
    assign cmd     = i_s_axis_tdata[CMD_W-1:0];
    assign number  = i_s_axis_tdata[CMD_W +: NUMBER_W];
    assign num_ext = NEXT_W'(number);
    assign tos_ext = VEXT_W'($signed(r_tos));
    assign is_op   = (cmd >= CMD_ADD) && (cmd <= CMD_AND);

    assign o_s_axis_tready = (r_state == S_IDLE) && (!r_ov || i_m_axis_tready);
    assign s_acc           = i_s_axis_tvalid && o_s_axis_tready;

    // Stack RAM holds every entry below the top of stack
    assign cnt_m1    = r_cnt - CNT_W'(1);
    assign cnt_m2    = r_cnt - CNT_W'(2);
    assign ram_waddr = cnt_m1[AW-1:0];
    assign ram_raddr = cnt_m2[AW-1:0];

    rpn_ram #(
        .WIDTH (W),
        .DEPTH (STACK_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (r_tos),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Left operand from RAM, right operand is top of stack
    assign opl    = ram_rdata;
    assign opr    = r_tos;
    assign sh_amt = opr[4:0];

    rpn_iter #(
        .DATA_WIDTH (W)
    ) u_iter (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (iter_ctl),
        .i_a      (opl),
        .i_b      (opr),
        .o_done   (iter_done),
        .o_result (iter_res)
    );

    // Combinational operators
    always_comb begin
        case (r_cmd)
            CMD_ADD: alu_res = opl + opr;
            CMD_SUB: alu_res = opl - opr;
            CMD_SHL: alu_res = opl << sh_amt;
            CMD_SHR: alu_res = W'($signed(opl) >>> sh_amt);
            CMD_XOR: alu_res = opl ^ opr;
            CMD_OR:  alu_res = opl | opr;
            default: alu_res = opl & opr;
        endcase
    end

    // Sequencer
    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_err    = r_err;
        n_cmd    = r_cmd;
        n_tos    = r_tos;
        n_ov     = r_ov;
        n_val    = r_val;
        n_sts    = r_sts;
        ram_we   = 1'b0;
        iter_ctl = '0;

        // Output transaction drains the result register
        if (r_ov && i_m_axis_tready) begin
            n_ov = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (s_acc) begin
                    if (cmd == CMD_PUSH) begin
                        if (r_cnt == CNT_W'(STACK_DEPTH)) begin
                            if (r_err == STS_OK) n_err = STS_OVERFLOW;
                        end else begin
                            ram_we = (r_cnt != '0);
                            n_tos  = num_ext[W-1:0];
                            n_cnt  = r_cnt + CNT_W'(1);
                        end
                    end else if (cmd == CMD_FINISH) begin
                        n_ov  = 1'b1;
                        n_val = (r_cnt != '0) ? tos_ext[VALUE_W-1:0] : '0;
                        n_sts = r_err;
                        n_cnt = '0;
                        n_err = STS_OK;
                    end else if (is_op) begin
                        if (r_cnt < CNT_W'(2)) begin
                            if (r_err == STS_OK) n_err = STS_UNDERFLOW;
                        end else begin
                            n_cmd   = cmd;
                            n_state = S_EXEC;
                        end
                    end
                end
            end
            S_EXEC: begin
                if (r_cmd == CMD_MUL) begin
                    iter_ctl.start  = 1'b1;
                    iter_ctl.op_div = 1'b0;
                    n_state         = S_ITER;
                end else if (r_cmd == CMD_DIV) begin
                    if (opr == '0) begin
                        if (r_err == STS_OK) n_err = STS_DIV_ZERO;
                        n_tos   = '0;
                        n_cnt   = cnt_m1;
                        n_state = S_IDLE;
                    end else begin
                        iter_ctl.start  = 1'b1;
                        iter_ctl.op_div = 1'b1;
                        n_state         = S_ITER;
                    end
                end else begin
                    n_tos   = alu_res;
                    n_cnt   = cnt_m1;
                    n_state = S_IDLE;
                end
            end
            S_ITER: begin
                if (iter_done) begin
                    n_tos   = iter_res;
                    n_cnt   = cnt_m1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_err   <= STS_OK;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_err   <= n_err;
            r_ov    <= n_ov;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
        r_tos <= n_tos;
        r_val <= n_val;
        r_sts <= n_sts;
    end

    assign o_m_axis_tvalid = r_ov;
    assign o_m_axis_tdata  = {(M_TDATA_W - VALUE_W - STATUS_W)'(0), r_sts, r_val};

endmodule

`default_nettype wire

// ===== sv/rpn_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rpn_checker
    import rpn_pkg::*;
(
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 i_s_axis_tvalid,
    input wire logic                 o_s_axis_tready,
    input wire logic [S_TDATA_W-1:0] i_s_axis_tdata,
    input wire logic                 o_m_axis_tvalid,
    input wire logic                 i_m_axis_tready,
    input wire logic [M_TDATA_W-1:0] o_m_axis_tdata
);

    logic fin_acc;

    assign fin_acc = i_s_axis_tvalid && o_s_axis_tready &&
                     (i_s_axis_tdata[CMD_W-1:0] == CMD_FINISH);

    // A stalled result holds its value and status
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
            (o_m_axis_tvalid && $stable(o_m_axis_tdata)))
        else $error("result changed or dropped while stalled");

    // Every finish transaction yields a result in the next cycle
    a_finish_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fin_acc |=> o_m_axis_tvalid)
        else $error("finish produced no result");

    // A result appears only after a finish transaction
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> $past(fin_acc))
        else $error("result without a finish");

    // Back-to-back finishes: the second sees an empty stack and no error
    a_empty_after_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fin_acc ##1 fin_acc) |=>
            (o_m_axis_tdata[VALUE_W+STATUS_W-1:0] == '0))
        else $error("stack or status not cleared by finish");

endmodule

bind rpn_stack_evaluator_unit rpn_checker u_rpn_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tdata  (i_s_axis_tdata),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

`default_nettype wire
